[sv/sfts_pkg.sv]
package sfts_pkg;

	localparam int SYMBOL_BITS   = 8;
	localparam int COUNT_BITS    = 32;
	localparam int TABLE_ENTRIES = 64;
	localparam int INDEX_BITS    = 6;

	typedef enum logic [1:0] {
		MODE_COUNT = 2'd0,
		MODE_SORT  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT    = 3'd0,
		ST_NEW    = 3'd1,
		ST_FULL   = 3'd2,
		ST_SORTED = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef struct packed {
		mode_t                  mode;
		logic [SYMBOL_BITS-1:0] symbol;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [SYMBOL_BITS-1:0] entry_symbol;
		logic [COUNT_BITS-1:0]  entry_count;
		logic [INDEX_BITS-1:0]  entry_index;
		logic                   last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CNT_RD, S_CNT_CMP, S_CNT_HIT, S_CNT_MISS, S_EMPTY,
		S_SRT_INIT, S_SRT_LOAD, S_SRT_CARRY, S_SRT_RD, S_SRT_CMP, S_SRT_END,
		S_EMIT_RD, S_EMIT_OUT
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE, RD_J, RD_J1
	} rd_op_t;

	typedef enum logic [2:0] {
		WR_NONE, WR_HIT, WR_NEW, WR_SWAP, WR_END
	} wr_op_t;

	typedef enum logic [2:0] {
		OUT_NONE, OUT_HIT, OUT_NEW, OUT_FULL, OUT_EMPTY, OUT_SORTED
	} out_op_t;

	typedef struct packed {
		logic    load_in;
		logic    clr_used;
		logic    inc_used;
		logic    j_clr;
		logic    j_inc;
		logic    lim_init;
		logic    lim_dec;
		logic    carry_load;
		rd_op_t  rd_op;
		wr_op_t  wr_op;
		out_op_t out_op;
	} cmd_t;

	typedef struct packed {
		logic j_at_used;
		logic hit;
		logic full;
		logic empty;
		logic used_one;
		logic lim_one;
		logic step_last;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

[sv/sfts_ctrl.sv]
module sfts_ctrl
	import sfts_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  mode_t req_mode,
	input  stat_t stat,
	output logic  req_stall,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req_mode)
						MODE_COUNT: state_d = S_CNT_RD;
						MODE_SORT:  state_d = S_SRT_INIT;
						MODE_CLEAR: state_d = S_EMPTY;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CNT_RD:    state_d = stat.j_at_used ? S_CNT_MISS : S_CNT_CMP;
			S_CNT_CMP:   state_d = stat.hit ? S_CNT_HIT : S_CNT_RD;
			S_CNT_HIT:   if (stat.out_free) state_d = S_IDLE;
			S_CNT_MISS:  if (stat.out_free) state_d = S_IDLE;
			S_EMPTY:     if (stat.out_free) state_d = S_IDLE;
			S_SRT_INIT: begin
				if (stat.empty) begin
					state_d = S_EMPTY;
				end else if (stat.used_one) begin
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_SRT_LOAD;
				end
			end
			S_SRT_LOAD:  state_d = S_SRT_CARRY;
			S_SRT_CARRY: state_d = S_SRT_RD;
			S_SRT_RD:    state_d = S_SRT_CMP;
			S_SRT_CMP:   state_d = stat.step_last ? S_SRT_END : S_SRT_RD;
			S_SRT_END:   state_d = stat.lim_one ? S_EMIT_RD : S_SRT_LOAD;
			S_EMIT_RD:   state_d = S_EMIT_OUT;
			S_EMIT_OUT: begin
				if (stat.out_free) begin
					state_d = stat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_op  = RD_NONE;
		cmd.wr_op  = WR_NONE;
		cmd.out_op = OUT_NONE;
		req_stall  = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.load_in = req_valid;
				cmd.j_clr   = 1'b1;
			end
			S_CNT_RD:  cmd.rd_op = RD_J;
			S_CNT_CMP: cmd.j_inc = !stat.hit;
			S_CNT_HIT: begin
				if (stat.out_free) begin
					cmd.wr_op  = WR_HIT;
					cmd.out_op = OUT_HIT;
				end
			end
			S_CNT_MISS: begin
				if (stat.out_free) begin
					if (stat.full) begin
						cmd.out_op = OUT_FULL;
					end else begin
						cmd.wr_op    = WR_NEW;
						cmd.out_op   = OUT_NEW;
						cmd.inc_used = 1'b1;
					end
				end
			end
			S_EMPTY: begin
				if (stat.out_free) begin
					cmd.clr_used = 1'b1;
					cmd.out_op   = OUT_EMPTY;
				end
			end
			S_SRT_INIT: begin
				cmd.lim_init = 1'b1;
				cmd.j_clr    = 1'b1;
			end
			S_SRT_LOAD:  cmd.rd_op = RD_J;
			S_SRT_CARRY: cmd.carry_load = 1'b1;
			S_SRT_RD:    cmd.rd_op = RD_J1;
			S_SRT_CMP: begin
				cmd.wr_op = WR_SWAP;
				cmd.j_inc = 1'b1;
			end
			S_SRT_END: begin
				cmd.wr_op   = WR_END;
				cmd.lim_dec = 1'b1;
				cmd.j_clr   = 1'b1;
			end
			S_EMIT_RD: cmd.rd_op = RD_J;
			S_EMIT_OUT: begin
				if (stat.out_free) begin
					cmd.out_op = OUT_SORTED;
					cmd.j_inc  = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

[sv/sfts_dp.sv]
module sfts_dp
	import sfts_pkg::*;
#(
	parameter int ENTRIES = TABLE_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	input  logic rsp_stall,
	output stat_t stat,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int UW = $clog2(ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [SYMBOL_BITS-1:0] sym_mem [ENTRIES];
	logic [COUNT_BITS-1:0]  cnt_mem [ENTRIES];

	logic [SYMBOL_BITS-1:0] rd_sym_q, sym_q, carry_sym_q, wr_sym;
	logic [COUNT_BITS-1:0]  rd_cnt_q, carry_cnt_q, wr_cnt, inc_cnt;
	logic [UW-1:0]          used_q, j_q, j_nxt;
	logic [IW-1:0]          lim_q, rd_addr, wr_addr;
	logic                   wr_en, rd_en, swap, out_valid_q, out_free;
	rsp_t                   out_q;

	assign j_nxt    = j_q + UW'(1);
	assign swap     = carry_cnt_q > rd_cnt_q;
	assign inc_cnt  = (rd_cnt_q == CNT_MAX) ? rd_cnt_q : rd_cnt_q + COUNT_BITS'(1);
	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		rd_en   = (cmd.rd_op != RD_NONE);
		rd_addr = j_q[IW-1:0];
		if (cmd.rd_op == RD_J1) begin
			rd_addr = j_nxt[IW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = j_q[IW-1:0];
		wr_sym  = rd_sym_q;
		wr_cnt  = inc_cnt;
		case (cmd.wr_op)
			WR_HIT: ;
			WR_NEW: begin
				wr_addr = used_q[IW-1:0];
				wr_sym  = sym_q;
				wr_cnt  = COUNT_BITS'(1);
			end
			WR_SWAP: begin
				wr_sym = swap ? rd_sym_q : carry_sym_q;
				wr_cnt = swap ? rd_cnt_q : carry_cnt_q;
			end
			WR_END: begin
				wr_addr = lim_q;
				wr_sym  = carry_sym_q;
				wr_cnt  = carry_cnt_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_mem[wr_addr] <= wr_sym;
			cnt_mem[wr_addr] <= wr_cnt;
		end
		if (rd_en) begin
			rd_sym_q <= sym_mem[rd_addr];
			rd_cnt_q <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sym_q <= req.symbol;
		end
		if (cmd.carry_load || (cmd.wr_op == WR_SWAP && !swap)) begin
			carry_sym_q <= rd_sym_q;
			carry_cnt_q <= rd_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			j_q    <= '0;
			lim_q  <= '0;
		end else begin
			if (cmd.clr_used) begin
				used_q <= '0;
			end else if (cmd.inc_used) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_nxt;
			end
			if (cmd.lim_init) begin
				lim_q <= IW'(used_q - UW'(1));
			end else if (cmd.lim_dec) begin
				lim_q <= lim_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_op != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_op != OUT_NONE) begin
			out_q.last         <= 1'b1;
			out_q.entry_symbol <= sym_q;
			out_q.entry_count  <= '0;
			out_q.entry_index  <= '0;
			case (cmd.out_op)
				OUT_HIT: begin
					out_q.status      <= ST_HIT;
					out_q.entry_count <= inc_cnt;
					out_q.entry_index <= INDEX_BITS'(j_q[IW-1:0]);
				end
				OUT_NEW: begin
					out_q.status      <= ST_NEW;
					out_q.entry_count <= COUNT_BITS'(1);
					out_q.entry_index <= INDEX_BITS'(used_q[IW-1:0]);
				end
				OUT_FULL: out_q.status <= ST_FULL;
				OUT_SORTED: begin
					out_q.status       <= ST_SORTED;
					out_q.entry_symbol <= rd_sym_q;
					out_q.entry_count  <= rd_cnt_q;
					out_q.entry_index  <= INDEX_BITS'(j_q[IW-1:0]);
					out_q.last         <= (j_nxt == used_q);
				end
				default: begin
					out_q.status       <= ST_EMPTY;
					out_q.entry_symbol <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		stat.j_at_used = (j_q == used_q);
		stat.hit       = (rd_sym_q == sym_q);
		stat.full      = (used_q == UW'(ENTRIES));
		stat.empty     = (used_q == '0);
		stat.used_one  = (used_q == UW'(1));
		stat.lim_one   = (lim_q == IW'(1));
		stat.step_last = (j_nxt == UW'(lim_q));
		stat.emit_last = (j_nxt == used_q);
		stat.out_free  = out_free;
	end

endmodule

[sv/symbol_frequency_table_sort_core.sv]
// Symbol occurrence table, first stage of a Huffman coder.
// req channel (req_valid/req_stall, payload req): one beat per command.
//   MODE_COUNT looks the symbol up and increments or appends it, one result;
//   a full table gives ST_FULL. MODE_SORT stably sorts by ascending count, then
//   one result per entry, last set on the final one; an empty table gives one
//   ST_EMPTY result. MODE_CLEAR empties the table, one ST_EMPTY result. Mode 3 is dropped.
// rsp channel (rsp_valid/rsp_stall, payload rsp): registered result beats.
// Timing: one command at a time; req_stall is low only when the controller
// is idle. Count searches the table entry by entry, set by the single-port
// table read. Sort runs passes of adjacent compare-and-swap steps, then
// reads the table out, one emitted beat per entry.
// A result beat sits in the output register while rsp_stall is high; the
// next command is still taken, and its result waits for the register.
// Reset empties the table; table contents need no clearing.
module symbol_frequency_table_sort_core
	import sfts_pkg::*;
#(
	parameter int ENTRIES = TABLE_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	sfts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	sfts_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

[sv/sfts_checker.sv]
module sfts_checker
	import sfts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed under stall");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_SORTED |-> rsp.last)
		else $error("single result without last");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == '0 && rsp.entry_index == '0)
		else $error("full result carries data");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NEW |-> rsp.entry_count == COUNT_BITS'(1))
		else $error("new entry count not one");

endmodule

bind symbol_frequency_table_sort_core sfts_checker u_sfts_checker (.*);

[tb/sv/testbench.sv]
module testbench;
	import sfts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	symbol_frequency_table_sort_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [SYMBOL_BITS-1:0] tbl_sym [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0]  tbl_cnt [TABLE_ENTRIES];
	int unsigned            tbl_used = 0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   send_idle_pct = 0;
	int   rcv_stall_pct = 0;
	int   error_count = 0;
	int   rsp_seen = 0;
	int   req_sent = 0;
	int   sorts_seen = 0;
	int   fulls_seen = 0;
	longint cycles = 0;
	logic req_taken = 1'b0;

	function automatic rsp_t make_rsp(status_t st, logic [SYMBOL_BITS-1:0] s,
			logic [COUNT_BITS-1:0] c, int idx, logic lst);
		rsp_t r;
		r.status = st;
		r.entry_symbol = s;
		r.entry_count = c;
		r.entry_index = idx[INDEX_BITS-1:0];
		r.last = lst;
		return r;
	endfunction

	task automatic predict_table(req_t r);
		logic [COUNT_BITS-1:0]  tc;
		logic [SYMBOL_BITS-1:0] ts;
		bit found;
		found = 0;
		case (r.mode)
			MODE_COUNT: begin
				for (int i = 0; i < tbl_used && !found; i++) begin
					if (tbl_sym[i] == r.symbol) begin
						found = 1;
						if (tbl_cnt[i] != COUNT_MAX) tbl_cnt[i] = tbl_cnt[i] + 1;
						expected_rsps.push_back(make_rsp(ST_HIT, r.symbol, tbl_cnt[i], i, 1'b1));
					end
				end
				if (!found) begin
					if (tbl_used < TABLE_ENTRIES) begin
						tbl_sym[tbl_used] = r.symbol;
						tbl_cnt[tbl_used] = 1;
						expected_rsps.push_back(make_rsp(ST_NEW, r.symbol, 1, tbl_used, 1'b1));
						tbl_used++;
					end else begin
						fulls_seen++;
						expected_rsps.push_back(make_rsp(ST_FULL, r.symbol, 0, 0, 1'b1));
					end
				end
			end
			MODE_SORT: begin
				sorts_seen++;
				if (tbl_used == 0) begin
					expected_rsps.push_back(make_rsp(ST_EMPTY, '0, 0, 0, 1'b1));
				end else begin
					for (int i = 0; i + 1 < tbl_used; i++)
						for (int j = 0; j + 1 < tbl_used - i; j++)
							if (tbl_cnt[j] > tbl_cnt[j+1]) begin
								tc = tbl_cnt[j]; ts = tbl_sym[j];
								tbl_cnt[j] = tbl_cnt[j+1]; tbl_sym[j] = tbl_sym[j+1];
								tbl_cnt[j+1] = tc; tbl_sym[j+1] = ts;
							end
					for (int i = 0; i < tbl_used; i++)
						expected_rsps.push_back(make_rsp(ST_SORTED, tbl_sym[i], tbl_cnt[i], i,
							i + 1 == tbl_used));
				end
			end
			MODE_CLEAR: begin
				tbl_used = 0;
				expected_rsps.push_back(make_rsp(ST_EMPTY, '0, 0, 0, 1'b1));
			end
			default: ;
		endcase
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// acceptance and result monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			req_sent <= req_sent + 1;
			predict_table(req);
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen <= rsp_seen + 1;
			if (expected_rsps.size() == 0) begin
				$error("unexpected result beat: %p", rsp);
				error_count++;
			end else begin
				automatic rsp_t e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status); error_count++;
				end
				if (rsp.entry_symbol !== e.entry_symbol) begin
					$error("entry_symbol: expected %0d, got %0d", e.entry_symbol,
						rsp.entry_symbol); error_count++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count,
						rsp.entry_count); error_count++;
				end
				if (rsp.entry_index !== e.entry_index) begin
					$error("entry_index: expected %0d, got %0d", e.entry_index,
						rsp.entry_index); error_count++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, rsp.last); error_count++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic req_t mk_req(mode_t m, logic [SYMBOL_BITS-1:0] s);
		req_t r;
		r.mode = m;
		r.symbol = s;
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_random(int n);
		int pick;
		logic [SYMBOL_BITS-1:0] alpha [8];
		for (int i = 0; i < 8; i++) alpha[i] = SYMBOL_BITS'($urandom_range(255));
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 3)
				pending_reqs.push_back(mk_req(MODE_SORT, SYMBOL_BITS'($urandom_range(255))));
			else if (pick < 5)
				pending_reqs.push_back(mk_req(MODE_CLEAR, SYMBOL_BITS'($urandom_range(255))));
			else if (pick < 7)
				pending_reqs.push_back(mk_req(MODE_NONE, SYMBOL_BITS'($urandom_range(255))));
			else if (pick < 60)
				pending_reqs.push_back(mk_req(MODE_COUNT, alpha[$urandom_range(7)]));
			else if (pick < 80)
				pending_reqs.push_back(mk_req(MODE_COUNT, SYMBOL_BITS'($urandom_range(255))));
			else
				pending_reqs.push_back(mk_req(MODE_COUNT, SYMBOL_BITS'($urandom_range(15))));
		end
		pending_reqs.push_back(mk_req(MODE_SORT, '0));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty sort, extremes, hits, clear, ignored mode
		pending_reqs.push_back(mk_req(MODE_SORT, 8'hff));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h00));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'hff));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'hff));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h55));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'haa));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h55));
		pending_reqs.push_back(mk_req(MODE_NONE, 8'h12));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h00));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h00));
		pending_reqs.push_back(mk_req(MODE_SORT, 8'h00));
		pending_reqs.push_back(mk_req(MODE_CLEAR, 8'h3c));
		pending_reqs.push_back(mk_req(MODE_SORT, 8'h00));
		// fill the table to capacity, then overflow
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h07));
		for (int i = 0; i < TABLE_ENTRIES; i++)
			pending_reqs.push_back(mk_req(MODE_COUNT, 8'(255 - i)));
		pending_reqs.push_back(mk_req(MODE_COUNT, 8'h07));
		pending_reqs.push_back(mk_req(MODE_SORT, 8'h00));
		pending_reqs.push_back(mk_req(MODE_CLEAR, 8'h00));
		wait_drained();

		// idle and stall phases, sender pauses for full drain between each
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 87) : 0;
			rcv_stall_pct = (ph == 2) ? 87 : ((ph == 3) ? 16 : 0);
			add_random(68);
			wait_drained();
		end
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		add_random(10);
		wait_drained();

		$display("sent %0d commands, checked %0d result beats (%0d sorts, %0d full drops)",
			req_sent, rsp_seen, sorts_seen, fulls_seen);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/sfts_pkg.sv
sv/sfts_ctrl.sv
sv/sfts_dp.sv
sv/symbol_frequency_table_sort_core.sv
sv/sfts_checker.sv
tb/sv/testbench.sv
